FILE: design/mlcrc_pkg.sv
// ----------------------------------------------------------------------------
// mlcrc_pkg
// Shared constants, types and the byte-wide CRC-8 update for the multi-line
// scratchpad frame checker.
// ----------------------------------------------------------------------------
package mlcrc_pkg;

  localparam int NumLines   = 4;
  localparam int NumLanes   = 4;
  localparam int FrameBytes = 9;

  localparam int LanesUsed = (NumLines > NumLanes) ? NumLanes : NumLines;
  localparam logic [NumLanes-1:0] LineMask = NumLanes'((1 << LanesUsed) - 1);
  localparam logic [3:0] LastIndex = 4'(FrameBytes - 1);

  localparam logic [7:0] CrcInit = 8'h00;
  localparam logic [7:0] CrcXor  = 8'h18;
  localparam logic [7:0] CrcTop  = 8'h80;

  typedef struct packed {
    logic en;
    logic first;
  } lane_ctrl_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data_in);
    logic [7:0] crc;
    logic [7:0] data;
    crc  = crc_in;
    data = data_in;
    for (int b = 0; b < 8; b++) begin
      if ((crc[0] ^ data[0]) == 1'b1) begin
        crc = ((crc ^ CrcXor) >> 1) | CrcTop;
      end else begin
        crc = crc >> 1;
      end
      data = data >> 1;
    end
    return crc;
  endfunction

endpackage

FILE: design/multi_line_scratchpad_crc_check.sv
// ----------------------------------------------------------------------------
// multi_line_scratchpad_crc_check
// Checks scratchpad frames read in parallel on four bus lines: latches line
// presence on the first byte, passes bytes of present lines, and reports the
// lines whose CRC-8 ends at zero on the last byte.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+-----------------------------------------
//  in      | in_valid_i / in_stall_o  | presence_levels_i, byte_lane0..3_i
//  out     | out_valid_o / out_stall_i| byte_index_o, lane_write_o,
//          |                          | out_byte_lane0..3_o, last_o, valid_mask_o
//  cfg     | cfg_we_i                 | cfg_wdata_i (requested_lines)
//
//  One item per cycle when not stalled; a result shows the cycle after accept.
//  The four CRC lanes update in parallel in the accepting cycle.
//  Reset clears the frame position, presence mask, lane CRCs and output valid;
//  requested_lines resets to all lines.
//  in_stall_o is high only while a held result is stalled downstream.
// ----------------------------------------------------------------------------
module multi_line_scratchpad_crc_check import mlcrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] presence_levels_i,
  input  logic [7:0] byte_lane0_i,
  input  logic [7:0] byte_lane1_i,
  input  logic [7:0] byte_lane2_i,
  input  logic [7:0] byte_lane3_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] byte_index_o,
  output logic [3:0] lane_write_o,
  output logic [7:0] out_byte_lane0_o,
  output logic [7:0] out_byte_lane1_o,
  output logic [7:0] out_byte_lane2_o,
  output logic [7:0] out_byte_lane3_o,
  output logic       last_o,
  output logic [3:0] valid_mask_o
);

  logic [3:0]          req_q;
  logic [3:0]          count_q;
  logic [3:0]          count_d;
  logic [NumLanes-1:0] present_q;
  logic [NumLanes-1:0] present_d;
  logic                accept;
  logic                first;
  logic                is_last;
  lane_ctrl_t          lane_ctrl;
  logic [7:0]          lane_in  [NumLanes];
  logic [7:0]          lane_out [NumLanes];
  logic [NumLanes-1:0] crc_ok;

  logic                out_valid_q;
  logic [3:0]          index_q;
  logic [3:0]          write_q;
  logic [7:0]          bytes_q  [NumLanes];
  logic                last_q;
  logic [3:0]          vmask_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign first      = (count_q == 4'd0);
  assign is_last    = (count_q == LastIndex);

  always_comb begin
    present_d = first ? (~presence_levels_i & req_q & LineMask) : present_q;
    count_d   = is_last ? 4'd0 : count_q + 4'd1;
    lane_ctrl.en    = accept;
    lane_ctrl.first = first;
    lane_in[0] = byte_lane0_i;
    lane_in[1] = byte_lane1_i;
    lane_in[2] = byte_lane2_i;
    lane_in[3] = byte_lane3_i;
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    mlcrc_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (lane_ctrl),
      .present_i (present_d[g]),
      .data_i    (lane_in[g]),
      .data_o    (lane_out[g]),
      .crc_ok_o  (crc_ok[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q       <= 4'hF;
      count_q     <= 4'd0;
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        req_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q   <= count_d;
        present_q <= present_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      index_q <= count_q;
      write_q <= present_d;
      bytes_q <= lane_out;
      last_q  <= is_last;
      vmask_q <= is_last ? crc_ok : 4'd0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign byte_index_o     = index_q;
  assign lane_write_o     = write_q;
  assign out_byte_lane0_o = bytes_q[0];
  assign out_byte_lane1_o = bytes_q[1];
  assign out_byte_lane2_o = bytes_q[2];
  assign out_byte_lane3_o = bytes_q[3];
  assign last_o           = last_q;
  assign valid_mask_o     = vmask_q;

`ifndef SYNTHESIS
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> byte_index_o == LastIndex)
    else $error("last result not at final frame position");

  a_mask_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> valid_mask_o == 4'd0)
    else $error("valid mask set before final byte");

  a_mask_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (valid_mask_o & ~lane_write_o) == 4'd0)
    else $error("valid mask names a line that is not present");

  a_present_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !first |=> present_q == $past(present_q))
    else $error("presence mask changed mid-frame");
`endif

endmodule

FILE: design/mlcrc_lane.sv
// ----------------------------------------------------------------------------
// mlcrc_lane
// One bus line: running CRC-8 register, byte gating and zero-check.
// ----------------------------------------------------------------------------
module mlcrc_lane import mlcrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lane_ctrl_t ctrl_i,
  input  logic       present_i,
  input  logic [7:0] data_i,
  output logic [7:0] data_o,
  output logic       crc_ok_o
);

  logic [7:0] crc_q;
  logic [7:0] crc_d;
  logic [7:0] crc_base;

  always_comb begin
    crc_base = ctrl_i.first ? CrcInit : crc_q;
    crc_d    = present_i ? crc8_byte(crc_base, data_i) : crc_base;
    data_o   = present_i ? data_i : 8'h00;
    crc_ok_o = present_i && (crc_d == 8'h00);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
    end else if (ctrl_i.en) begin
      crc_q <= crc_d;
    end
  end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-line scratchpad frame checker. A short
// table of frames (all zero, no device, alternating patterns) runs first,
// then random phases under different line requests. Most random frames end
// in the correct CRC byte on every present line, and some end in noise. An
// in-bench model of the presence latch and the per-line CRC-8 predicts every
// item, and the scoreboard compares each output field in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int FRAME_LEN = mlcrc_pkg::FrameBytes;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 100;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [3:0]      levels;
    logic [3:0][7:0] lanes;
  } frame_item_t;

  typedef struct packed {
    logic [3:0]      pos;
    logic [3:0]      wr_mask;
    logic [3:0][7:0] lanes;
    logic            is_last;
    logic [3:0]      ok_mask;
  } scratch_result_t;

  typedef struct {
    frame_item_t     item;
    bit              typed;
    scratch_result_t want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = 4'h0;
  logic in_valid = 1'b0;
  logic in_stall;
  frame_item_t drive_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_pos;
  logic [3:0] out_wr_mask;
  logic [7:0] out_lane0;
  logic [7:0] out_lane1;
  logic [7:0] out_lane2;
  logic [7:0] out_lane3;
  logic out_last;
  logic [3:0] out_ok_mask;

  logic [3:0] req_lines;
  logic [3:0] frame_pos;
  logic [3:0] live_lines;
  logic [7:0] run_crc [4];

  scratch_result_t expected_q [$];
  table_row_t table_rows [$];
  int errors = 0;
  int cycles = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  multi_line_scratchpad_crc_check dut (
    .clk_i                     (clk),
    .rst_ni                    (rst_n),
    .cfg_we_i                  (cfg_we),
    .cfg_wdata_i               (cfg_wdata),
    .in_valid_i                (in_valid),
    .in_stall_o                (in_stall),
    .presence_levels_i         (drive_item.levels),
    .byte_lane0_i              (drive_item.lanes[0]),
    .byte_lane1_i              (drive_item.lanes[1]),
    .byte_lane2_i              (drive_item.lanes[2]),
    .byte_lane3_i              (drive_item.lanes[3]),
    .out_valid_o               (out_valid),
    .out_stall_i               (out_stall),
    .byte_index_o              (out_pos),
    .lane_write_o              (out_wr_mask),
    .out_byte_lane0_o          (out_lane0),
    .out_byte_lane1_o          (out_lane1),
    .out_byte_lane2_o          (out_lane2),
    .out_byte_lane3_o          (out_lane3),
    .last_o                    (out_last),
    .valid_mask_o              (out_ok_mask)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
    end
    return c;
  endfunction

  function automatic scratch_result_t predict_scratch(input frame_item_t it);
    scratch_result_t r;
    r = '0;
    if (frame_pos == 4'd0) begin
      live_lines = ~it.levels & req_lines & mlcrc_pkg::LineMask;
      for (int l = 0; l < 4; l++) run_crc[l] = 8'h00;
    end
    r.pos = frame_pos;
    r.wr_mask = live_lines;
    for (int l = 0; l < 4; l++) begin
      if (live_lines[l]) begin
        r.lanes[l] = it.lanes[l];
        run_crc[l] = crc8_step(run_crc[l], it.lanes[l]);
      end
    end
    r.is_last = (int'(frame_pos) == FRAME_LEN - 1);
    if (r.is_last) begin
      for (int l = 0; l < 4; l++) r.ok_mask[l] = live_lines[l] && (run_crc[l] == 8'h00);
      frame_pos = 4'd0;
    end else begin
      frame_pos = frame_pos + 4'd1;
    end
    return r;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic frame_item_t make_item();
    frame_item_t it;
    it.levels = $urandom_range(0, 1) ? 4'h0 : 4'($urandom_range(0, 15));
    for (int l = 0; l < 4; l++) it.lanes[l] = 8'($urandom);
    if (int'(frame_pos) == FRAME_LEN - 1 && $urandom_range(0, 4) != 0) begin
      for (int l = 0; l < 4; l++) begin
        if (live_lines[l]) it.lanes[l] = run_crc[l];
      end
    end
    return it;
  endfunction

  function automatic void check_field(input string name, input int want, input int seen);
    if (want != seen) begin
      errors++;
      $display("%0t %s expected %0h actual %0h", $time, name, want, seen);
    end
  endfunction

  // call right after a rising edge; returns at the edge that takes the item
  task automatic push_item(input frame_item_t it, input bit typed, input scratch_result_t want);
    int gap;
    scratch_result_t predicted;
    gap = calm ? 0 : ($urandom_range(0, 1) ? 0 : pick_len());
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    drive_item <= it;
    do @(posedge clk); while (in_stall);
    predicted = predict_scratch(it);
    expected_q.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_lines(input logic [3:0] mask);
    cfg_we <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we <= 1'b0;
    req_lines = mask;
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_len();
    end
  end

  always @(posedge clk) begin : scoreboard
    scratch_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t result with none expected: expected none actual index %0h",
                 $time, out_pos);
      end else begin
        want = expected_q.pop_front();
        check_field("byte_index", want.pos, out_pos);
        check_field("lane_write", want.wr_mask, out_wr_mask);
        check_field("out_byte_lane0", want.lanes[0], out_lane0);
        check_field("out_byte_lane1", want.lanes[1], out_lane1);
        check_field("out_byte_lane2", want.lanes[2], out_lane2);
        check_field("out_byte_lane3", want.lanes[3], out_lane3);
        check_field("last", want.is_last, out_last);
        check_field("valid_mask", want.ok_mask, out_ok_mask);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    table_row_t row;
    logic [7:0] pattern [4];
    logic [3:0] lines_plan [PHASES];
    pattern = '{8'hFF, 8'h00, 8'hA5, 8'h5A};
    lines_plan = '{4'h0, 4'hF, 4'h5, 4'hA, 4'h1, 4'h8, 4'h0, 4'h0, 4'hF};
    lines_plan[6] = 4'($urandom_range(0, 15));
    lines_plan[7] = 4'($urandom_range(0, 15));
    req_lines = 4'hF;
    frame_pos = 4'd0;
    live_lines = 4'h0;
    for (int l = 0; l < 4; l++) run_crc[l] = 8'h00;

    // all lines present, all-zero bytes: every CRC ends at zero
    for (int i = 0; i < FRAME_LEN; i++) begin
      row.item = '0;
      row.typed = 1'b1;
      row.want = '0;
      row.want.pos = 4'(i);
      row.want.wr_mask = 4'hF;
      row.want.is_last = (i == FRAME_LEN - 1);
      row.want.ok_mask = (i == FRAME_LEN - 1) ? 4'hF : 4'h0;
      table_rows.push_back(row);
    end
    // no device on any line: nothing passes
    for (int i = 0; i < FRAME_LEN; i++) begin
      row.item.levels = 4'hF;
      row.item.lanes = '1;
      row.typed = 1'b1;
      row.want = '0;
      row.want.pos = 4'(i);
      row.want.is_last = (i == FRAME_LEN - 1);
      table_rows.push_back(row);
    end
    // lines 0 and 2 present, frame left open for a mid-frame register write
    for (int i = 0; i < FRAME_LEN - 2; i++) begin
      row.item.levels = 4'b1010;
      for (int l = 0; l < 4; l++) row.item.lanes[l] = pattern[(i + l) % 4];
      row.typed = 1'b0;
      row.want = '0;
      table_rows.push_back(row);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i]) push_item(table_rows[i].item, table_rows[i].typed, table_rows[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      calm = (ph == 3 || ph == 7);
      write_lines(lines_plan[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) push_item(make_item(), 1'b0, '0);
    end
    drain();
    calm = 1'b0;
    repeat (5) @(posedge clk);

    if (errors == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/mlcrc_pkg.sv
design/mlcrc_lane.sv
design/multi_line_scratchpad_crc_check.sv
bench/tb.sv
